// ===== design/ols_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list store.
package ols_pkg;

   localparam int OLS_DEPTH   = 32;  // default number of entries
   localparam int OLS_MAX_OUT = 32;  // most beats a traverse emits
   localparam int DATA_W      = 32;
   localparam int POS_W       = 5;
   localparam int TDATA_W     = 40;  // data + index, padded to whole bytes

   typedef enum logic [1:0] {
      FN_INSERT   = 2'd0,
      FN_DELETE   = 2'd1,
      FN_SEARCH   = 2'd2,
      FN_TRAVERSE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;      // latch search value, set walk pointer
      logic       ptr_from_pos;  // walk pointer starts at the delete position
      logic       mem_rd;        // read entry at walk pointer, advance pointer
      logic       rd_take;       // read data has been used
      logic       wr_ins;        // append request value at the tail
      logic       wr_shift;      // move read entry down by one place
      logic       cnt_dec;
      logic       out_load;
      status_type out_status;
      logic       out_use_data;
      logic       out_use_idx;
      logic       out_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_over;   // request position at or past the count
      logic ptr_more;   // walk pointer below the count
      logic trav_more;  // walk pointer below the traverse limit
      logic trav_last;  // read entry is the final traverse beat
      logic rd_vld;
      logic match;
      logic out_free;
   } sts_type;

endpackage

// ===== design/ordered_list_store.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list store: controller, datapath and checks.
// An ordered list of up to DEPTH signed 32-bit values held in a single-port-read
// memory. On delete the entries behind the removed one are moved down one a
// cycle through the memory's one read port; the delete's result beat is loaded
// in S_DEL_HEAD, before the shift. Search reads one entry a cycle.
// Traverse emits min(count, 32) beats, one a cycle, slowed only by
// back-pressure on the result side. A new request is taken only once the
// previous operation is finished and the result register can load.
// Reset clears the count, pointer and valid flags; entries need no clearing pass.
module ordered_list_store #(
   parameter int DEPTH = ols_pkg::OLS_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ols_pkg::TDATA_W-1:0] req_tdata,  // [31:0] value, [36:32] position
   input  logic [1:0]                  req_tuser,  // [1:0] func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ols_pkg::TDATA_W-1:0] rsp_tdata,  // [31:0] data, [36:32] index
   output logic [2:0]                  rsp_tuser,  // [2:0] status
   output logic                        rsp_tlast
);
   import ols_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ols_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   ols_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_value    (req_tdata[DATA_W-1:0]),
      .req_position (req_tdata[DATA_W+POS_W-1:DATA_W]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   // never load the result register over a beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register loaded while holding a stalled beat");

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken while a result beat is stalled");

   a_full_insert_holds: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == FN_INSERT && sts.full) |=> sts.full)
      else $error("insert into a full store changed the count");

endmodule

// ===== design/ols_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: entry memory, count, walk pointer, read register and result register.
module ols_dpath #(
   parameter int DEPTH = ols_pkg::OLS_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ols_pkg::cmd_type              cmd,
   output ols_pkg::sts_type              sts,
   input  logic [ols_pkg::DATA_W-1:0]    req_value,
   input  logic [ols_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ols_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import ols_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;  // common width for compares

   logic [DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     rd_idx_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff, rd_vld_in;
   logic [DATA_W-1:0] value_ff;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [POS_W-1:0]  out_index_ff;
   logic              out_last_ff;

   logic [XW-1:0]     count_x, ptr_x, pos_x, idx_x, lim_x;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign count_x = XW'(count_ff);
   assign ptr_x   = XW'(ptr_ff);
   assign pos_x   = XW'(req_position);
   assign idx_x   = XW'(rd_idx_ff);
   assign lim_x   = (count_x > XW'(OLS_MAX_OUT)) ? XW'(OLS_MAX_OUT) : count_x;

   assign sts.full      = (count_ff == CW'(DEPTH));
   assign sts.empty     = (count_ff == '0);
   assign sts.pos_over  = (pos_x >= count_x);
   assign sts.ptr_more  = (ptr_x < count_x);
   assign sts.trav_more = (ptr_x < lim_x);
   assign sts.trav_last = (XW'(idx_x + XW'(1)) == lim_x);
   assign sts.rd_vld    = rd_vld_ff;
   assign sts.match     = (rd_data_ff == value_ff);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (cmd.wr_ins) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (cmd.cnt_dec) begin
         count_in = CW'(count_ff - CW'(1));
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load_req) begin
         ptr_in = cmd.ptr_from_pos ? CW'(req_position) : '0;
      end else if (cmd.mem_rd) begin
         ptr_in = CW'(ptr_ff + CW'(1));
      end
   end

   assign rd_vld_in    = cmd.mem_rd || (rd_vld_ff && !cmd.rd_take);
   assign out_valid_in = cmd.out_load || (out_valid_ff && !rsp_tready);

   // single write port: tail append or one-place shift during delete
   assign wr_en   = cmd.wr_ins || cmd.wr_shift;
   assign wr_addr = cmd.wr_ins ? count_ff[AW-1:0] : AW'(rd_idx_ff - CW'(1));
   assign wr_data = cmd.wr_ins ? req_value : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[ptr_ff[AW-1:0]];
         rd_idx_ff  <= ptr_ff;
      end
      if (cmd.load_req) begin
         value_ff <= req_value;
      end
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_data_ff   <= cmd.out_use_data ? rd_data_ff : '0;
         out_index_ff  <= cmd.out_use_idx ? POS_W'(rd_idx_ff) : '0;
         out_last_ff   <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - DATA_W - POS_W){1'b0}}, out_index_ff, out_data_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/ols_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: operation sequencing for insert, delete, search and traverse.
module ols_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_func,
   input  ols_pkg::sts_type sts,
   output ols_pkg::cmd_type cmd
);
   import ols_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_DEL_RD    = 6'b000010,
      S_DEL_HEAD  = 6'b000100,
      S_DEL_SHIFT = 6'b001000,
      S_SRCH      = 6'b010000,
      S_TRAV      = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      take;
   logic      trav_load;

   // only used in idle, where ready is the result slot being free
   assign take      = req_tvalid && sts.out_free;
   assign trav_load = sts.rd_vld && sts.out_free;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.out_status = ST_OK;
      cmd.out_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_tready = sts.out_free;
            if (take) begin
               case (func_type'(req_func))
                  FN_INSERT: begin
                     cmd.out_load = 1'b1;
                     if (sts.full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.wr_ins = 1'b1;
                     end
                  end
                  FN_DELETE: begin
                     if (sts.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else if (sts.pos_over) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_RANGE;
                     end else begin
                        cmd.load_req     = 1'b1;
                        cmd.ptr_from_pos = 1'b1;
                        state_in         = S_DEL_RD;
                     end
                  end
                  FN_SEARCH: begin
                     if (sts.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NOTFOUND;
                     end else begin
                        cmd.load_req = 1'b1;
                        state_in     = S_SRCH;
                     end
                  end
                  FN_TRAVERSE: begin
                     if (sts.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.load_req = 1'b1;
                        state_in     = S_TRAV;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_DEL_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_DEL_HEAD;
         end
         S_DEL_HEAD: begin
            // read data is the removed entry; report it now, then close the gap
            cmd.rd_take      = 1'b1;
            cmd.out_load     = 1'b1;
            cmd.out_use_data = 1'b1;
            if (sts.ptr_more) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_DEL_SHIFT;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DEL_SHIFT: begin
            cmd.rd_take  = 1'b1;
            cmd.wr_shift = 1'b1;
            if (sts.ptr_more) begin
               cmd.mem_rd = 1'b1;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SRCH: begin
            cmd.rd_take = 1'b1;
            if (sts.rd_vld && sts.match) begin
               cmd.out_load    = 1'b1;
               cmd.out_use_idx = 1'b1;
               state_in        = S_IDLE;
            end else if (sts.ptr_more) begin
               cmd.mem_rd = 1'b1;
            end else begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_NOTFOUND;
               state_in       = S_IDLE;
            end
         end
         S_TRAV: begin
            // one entry in flight; next read issues as soon as its slot frees
            cmd.out_last = sts.trav_last;
            if (trav_load) begin
               cmd.out_load     = 1'b1;
               cmd.out_use_data = 1'b1;
               cmd.out_use_idx  = 1'b1;
               cmd.rd_take      = 1'b1;
               if (sts.trav_last) begin
                  state_in = S_IDLE;
               end
            end
            cmd.mem_rd = sts.trav_more && (!sts.rd_vld || trav_load) &&
                         !(trav_load && sts.trav_last);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
